// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define RK4_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequent required in the cycle after the antecedent
`define RK4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rk4smd_pkg.sv -----
// shared types, constants and helpers of the rk4 spring-mass-damper step block
// no dependencies; imported by every rtl module of the block
package rk4smd_pkg;

  // fixed-point format
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 31;
  localparam int ACC_W      = 36;
  localparam int CFG_ADDR_W = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_INV_MASS    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DAMPING     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STIFFNESS   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_TIME   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REST_OFFSET = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0]         RST_INV_MASS    = 31'd65536;
  localparam logic [CFG_W-1:0]         RST_DAMPING     = 31'd0;
  localparam logic [CFG_W-1:0]         RST_STIFFNESS   = 31'd0;
  localparam logic [CFG_W-1:0]         RST_STEP_TIME   = 31'd655;
  localparam logic signed [DATA_W-1:0] RST_REST_OFFSET = 32'sd5243;

  // saturation limits and product rounding constant
  localparam logic signed [63:0] S32_MAX    = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN    = -64'sd2147483648;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // multiplier operand selects
  typedef enum logic [2:0] {
    MA_STIFF,
    MA_DAMP,
    MA_IMASS,
    MA_HDT,
    MA_DT
  } mul_a_sel_e;

  typedef enum logic [2:0] {
    MB_XO,
    MB_TV,
    MB_NET,
    MB_KV,
    MB_SX,
    MB_SV
  } mul_b_sel_e;

  // writeback operations
  typedef enum logic [3:0] {
    WB_NONE,
    WB_XO,
    WB_NP,
    WB_NET,
    WB_KV,
    WB_TX,
    WB_TV,
    WB_POS,
    WB_VEL
  } wb_op_e;

  typedef struct packed {
    logic       load;
    mul_a_sel_e mul_a;
    mul_b_sel_e mul_b;
    wb_op_e     wb_op;
    logic       acc_x;
    logic       acc_dbl;
    logic       div_start;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[DATA_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/rk4smd_div6.sv -----
// byte-serial round-to-nearest divide by six with 32-bit saturation
// depends on rk4smd_pkg
module rk4smd_div6 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [rk4smd_pkg::ACC_W-1:0]   dividend_i,
  output logic                                  done_o,
  output logic signed [rk4smd_pkg::DATA_W-1:0]  quot_o
);
  import rk4smd_pkg::*;

  localparam int DIV_BYTES = 5;
  localparam int DIV_W     = 8 * DIV_BYTES;
  localparam int RECIP_SH  = 13;
  localparam logic [21:0]      RECIP6   = 22'd1366;
  localparam logic [DIV_W-1:0] DIV_BIAS = 40'd3 << 35;
  localparam logic signed [DIV_W:0] QUO_BIAS = 41'sd1 <<< 34;
  localparam logic [2:0] LAST_STEP = 3'(DIV_BYTES - 1);

  logic [DIV_W-1:0]  u_q;
  logic [DIV_W-1:0]  quo_q;
  logic [2:0]        rem_q;
  logic [2:0]        cnt_q;
  logic              busy_q;
  logic              fin_q;
  logic              done_q;
  logic signed [DATA_W-1:0] res_q;

  logic [10:0]       val;
  logic [21:0]       prod;
  logic [7:0]        q8;
  logic [10:0]       rem11;
  logic signed [DIV_W:0] quo_unb;

  // one quotient byte per step: remainder and next byte over six
  assign val     = {rem_q, u_q[DIV_W-1 -: 8]};
  assign prod    = 22'(val) * RECIP6;
  assign q8      = prod[RECIP_SH +: 8];
  assign rem11   = val - ({3'b000, q8} << 2) - ({3'b000, q8} << 1);
  assign quo_unb = signed'({1'b0, quo_q}) - QUO_BIAS;

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // biased dividend, quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q   <= DIV_W'(dividend_i) + DIV_W'(3) + DIV_BIAS;
      rem_q <= '0;
    end else if (busy_q) begin
      u_q   <= {u_q[DIV_W-9:0], 8'h00};
      quo_q <= {quo_q[DIV_W-9:0], q8};
      rem_q <= rem11[2:0];
    end
    if (fin_q) begin
      res_q <= sat32(64'(quo_unb));
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

// ----- src/rk4smd_datapath.sv -----
// datapath: config registers, state, shared multiplier with rounding, writeback
// and the two divide-by-six lanes; depends on rk4smd_pkg and rk4smd_div6
module rk4smd_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [rk4smd_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [rk4smd_pkg::DATA_W-1:0]          cfg_wdata_i,
  input  logic signed [rk4smd_pkg::DATA_W-1:0]   force_req_i,
  input  rk4smd_pkg::dp_cmd_t                    cmd_i,
  output rk4smd_pkg::dp_status_t                 status_o,
  output logic signed [rk4smd_pkg::DATA_W-1:0]   new_position_o,
  output logic signed [rk4smd_pkg::DATA_W-1:0]   new_velocity_o
);
  import rk4smd_pkg::*;

  logic [CFG_W-1:0]         inv_mass_q, damping_q, stiffness_q, step_time_q;
  logic signed [DATA_W-1:0] rest_offset_q;

  logic signed [DATA_W-1:0] x_q, v_q;
  logic signed [DATA_W-1:0] f_q, tx_q, tv_q, xo_q, net_q, kv_q;
  logic signed [33:0]       np_q;
  logic signed [ACC_W-1:0]  acc_x_q, acc_v_q;
  logic signed [63:0]       prod_q;
  logic signed [DATA_W-1:0] res_q;
  logic signed [DATA_W-1:0] pos_out_q, vel_out_q;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]       rnd_shift;
  logic signed [32:0]       xo_sum, xr_sum, vr_sum;
  logic signed [33:0]       np_diff;
  logic signed [34:0]       net_diff;
  logic signed [ACC_W-1:0]  tv_ext, tv_add, res_ext, res_add;
  logic signed [DATA_W-1:0] sx, sv;
  logic                     done_x, done_v;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q    <= RST_INV_MASS;
      damping_q     <= RST_DAMPING;
      stiffness_q   <= RST_STIFFNESS;
      step_time_q   <= RST_STEP_TIME;
      rest_offset_q <= RST_REST_OFFSET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_INV_MASS:    inv_mass_q    <= cfg_wdata_i[CFG_W-1:0];
        CFG_DAMPING:     damping_q     <= cfg_wdata_i[CFG_W-1:0];
        CFG_STIFFNESS:   stiffness_q   <= cfg_wdata_i[CFG_W-1:0];
        CFG_STEP_TIME:   step_time_q   <= cfg_wdata_i[CFG_W-1:0];
        CFG_REST_OFFSET: rest_offset_q <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // multiplier operand a
  always_comb begin
    case (cmd_i.mul_a)
      MA_STIFF: mul_a = signed'({1'b0, stiffness_q});
      MA_DAMP:  mul_a = signed'({1'b0, damping_q});
      MA_IMASS: mul_a = signed'({1'b0, inv_mass_q});
      MA_HDT:   mul_a = signed'({2'b00, step_time_q[CFG_W-1:1]});
      MA_DT:    mul_a = signed'({1'b0, step_time_q});
      default:  mul_a = '0;
    endcase
  end

  // multiplier operand b
  always_comb begin
    case (cmd_i.mul_b)
      MB_XO:   mul_b = xo_q;
      MB_TV:   mul_b = tv_q;
      MB_NET:  mul_b = net_q;
      MB_KV:   mul_b = kv_q;
      MB_SX:   mul_b = sx;
      MB_SV:   mul_b = sv;
      default: mul_b = '0;
    endcase
  end

  // product, then round to nearest and saturate in the following cycle
  assign rnd_shift = (prod_q + ROUND_HALF) >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    res_q  <= sat32(rnd_shift);
  end

  // writeback arithmetic
  assign xo_sum   = 33'(tx_q) + 33'(rest_offset_q);
  assign xr_sum   = 33'(x_q) + 33'(res_q);
  assign vr_sum   = 33'(v_q) + 33'(res_q);
  assign np_diff  = 34'(f_q) - 34'(res_q);
  assign net_diff = 35'(np_q) - 35'(res_q);
  assign tv_ext   = ACC_W'(tv_q);
  assign tv_add   = cmd_i.acc_dbl ? (tv_ext <<< 1) : tv_ext;
  assign res_ext  = ACC_W'(res_q);
  assign res_add  = cmd_i.acc_dbl ? (res_ext <<< 1) : res_ext;

  // kept state: position and velocity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      v_q <= '0;
    end else begin
      case (cmd_i.wb_op)
        WB_POS:  x_q <= sat32(64'(xr_sum));
        WB_VEL:  v_q <= sat32(64'(vr_sum));
        default: ;
      endcase
    end
  end

  // trial point, slope terms and weighted sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q     <= force_req_i;
      tx_q    <= x_q;
      tv_q    <= v_q;
      acc_x_q <= '0;
      acc_v_q <= '0;
    end else begin
      if (cmd_i.acc_x) begin
        acc_x_q <= acc_x_q + tv_add;
      end
      case (cmd_i.wb_op)
        WB_XO:  xo_q  <= sat32(64'(xo_sum));
        WB_NP:  np_q  <= np_diff;
        WB_NET: net_q <= sat32(64'(net_diff));
        WB_KV: begin
          kv_q    <= res_q;
          acc_v_q <= acc_v_q + res_add;
        end
        WB_TX:   tx_q <= sat32(64'(xr_sum));
        WB_TV:   tv_q <= sat32(64'(vr_sum));
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      pos_out_q <= x_q;
      vel_out_q <= v_q;
    end
  end

  // divide-by-six lanes for the position and velocity sums
  rk4smd_div6 u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_x_q),
    .done_o     (done_x),
    .quot_o     (sx)
  );

  rk4smd_div6 u_div_v (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_v_q),
    .done_o     (done_v),
    .quot_o     (sv)
  );

  assign status_o.div_done = done_x & done_v;
  assign new_position_o    = pos_out_q;
  assign new_velocity_o    = vel_out_q;

endmodule

// ----- src/rk4smd_ctrl.sv -----
// controller: sequences the four slope evaluations, the divide and the final update
// depends on rk4smd_pkg
module rk4smd_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  rk4smd_pkg::dp_status_t  status_i,
  output rk4smd_pkg::dp_cmd_t     cmd_o
);
  import rk4smd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DIVW = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // slope stages; the first one only forms the spring term of k1
  localparam logic [2:0] STG_PRE = 3'd0;
  localparam logic [2:0] STG_K1  = 3'd1;
  localparam logic [2:0] STG_K2  = 3'd2;
  localparam logic [2:0] STG_K3  = 3'd3;
  localparam logic [2:0] STG_K4  = 3'd4;

  // phases inside one stage
  localparam logic [3:0] PH_DAMP  = 4'd0;
  localparam logic [3:0] PH_HTV   = 4'd1;
  localparam logic [3:0] PH_NET   = 4'd2;
  localparam logic [3:0] PH_IMASS = 4'd3;
  localparam logic [3:0] PH_XO    = 4'd4;
  localparam logic [3:0] PH_KV    = 4'd5;
  localparam logic [3:0] PH_HKV   = 4'd6;
  localparam logic [3:0] PH_NP    = 4'd7;
  localparam logic [3:0] PH_TV    = 4'd8;

  // phases of the final update
  localparam logic [3:0] FN_SV  = 4'd1;
  localparam logic [3:0] FN_POS = 4'd2;
  localparam logic [3:0] FN_VEL = 4'd3;
  localparam logic [3:0] FN_OUT = 4'd4;

  logic [1:0] state_q, state_d;
  logic [2:0] stage_q, stage_d;
  logic [3:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;

  logic       real_stg, trial_stg, next_stg, dbl;
  mul_a_sel_e h_sel;

  assign real_stg  = (stage_q != STG_PRE);
  assign trial_stg = real_stg && (stage_q != STG_K4);
  assign next_stg  = (stage_q != STG_K4);
  assign dbl       = (stage_q == STG_K2) || (stage_q == STG_K3);
  assign h_sel     = (stage_q == STG_K3) ? MA_DT : MA_HDT;

  // command decode and next state
  always_comb begin
    cmd_o       = '0;
    cmd_o.wb_op = WB_NONE;
    state_d     = state_q;
    stage_d     = stage_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          stage_d    = STG_PRE;
          phase_d    = PH_XO;
        end
      end
      ST_RUN: begin
        case (phase_q)
          PH_DAMP: begin
            if (real_stg) begin
              cmd_o.mul_a   = MA_DAMP;
              cmd_o.mul_b   = MB_TV;
              cmd_o.acc_x   = 1'b1;
              cmd_o.acc_dbl = dbl;
            end
          end
          PH_HTV: begin
            if (trial_stg) begin
              cmd_o.mul_a = h_sel;
              cmd_o.mul_b = MB_TV;
            end
          end
          PH_NET: begin
            if (real_stg) begin
              cmd_o.wb_op = WB_NET;
            end
          end
          PH_IMASS: begin
            if (real_stg) begin
              cmd_o.mul_a = MA_IMASS;
              cmd_o.mul_b = MB_NET;
            end
            if (trial_stg) begin
              cmd_o.wb_op = WB_TX;
            end
          end
          PH_XO: begin
            if (next_stg) begin
              cmd_o.wb_op = WB_XO;
            end
          end
          PH_KV: begin
            if (real_stg) begin
              cmd_o.wb_op   = WB_KV;
              cmd_o.acc_dbl = dbl;
            end
            if (next_stg) begin
              cmd_o.mul_a = MA_STIFF;
              cmd_o.mul_b = MB_XO;
            end
          end
          PH_HKV: begin
            if (trial_stg) begin
              cmd_o.mul_a = h_sel;
              cmd_o.mul_b = MB_KV;
            end
            if (!next_stg) begin
              cmd_o.div_start = 1'b1;
            end
          end
          PH_NP: begin
            if (next_stg) begin
              cmd_o.wb_op = WB_NP;
            end
          end
          PH_TV: begin
            if (trial_stg) begin
              cmd_o.wb_op = WB_TV;
            end
          end
          default: ;
        endcase
        // advance through phases and stages
        if (!next_stg && phase_q == PH_HKV) begin
          state_d = ST_DIVW;
        end else if (phase_q == PH_TV) begin
          phase_d = PH_DAMP;
          stage_d = stage_q + 3'd1;
        end else begin
          phase_d = phase_q + 4'd1;
        end
      end
      ST_DIVW: begin
        if (status_i.div_done) begin
          cmd_o.mul_a = MA_DT;
          cmd_o.mul_b = MB_SX;
          state_d     = ST_FIN;
          phase_d     = FN_SV;
        end
      end
      ST_FIN: begin
        case (phase_q)
          FN_SV: begin
            cmd_o.mul_a = MA_DT;
            cmd_o.mul_b = MB_SV;
          end
          FN_POS:  cmd_o.wb_op = WB_POS;
          FN_VEL:  cmd_o.wb_op = WB_VEL;
          default: ;
        endcase
        if (phase_q == FN_OUT) begin
          if (!out_valid_q || out_ready_i) begin
            cmd_o.out_load = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          phase_d = phase_q + 4'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= STG_PRE;
      phase_q     <= PH_DAMP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/rk4_spring_mass_damper_step.sv -----
// top level of the rk4 spring-mass-damper step block
// depends on rk4smd_pkg, rk4smd_ctrl and rk4smd_datapath
//
// Each accepted force beat advances the kept position and velocity by one
// fourth-order Runge-Kutta step and returns the new pair as one result beat.
// Values are signed Q16.16 and saturate at the 32-bit limits. Registers are
// to be written through the plain write port only while the block is idle;
// the block itself does not enforce this. The step is a chain of dependent
// products through the one shared 32x32 multiplier, which registers the
// product and then the rounded result before writeback, followed by the
// byte-serial divide by six and the two final products. The next force beat
// is accepted in the cycle the result is shown; an unread result sits in the
// output register while the next step runs.
module rk4_spring_mass_damper_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rk4smd_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [rk4smd_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [rk4smd_pkg::DATA_W-1:0]  force_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rk4smd_pkg::DATA_W-1:0]  new_position_o,
  output logic signed [rk4smd_pkg::DATA_W-1:0]  new_velocity_o
);
  import rk4smd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  rk4smd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  rk4smd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .force_req_i    (force_req_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .new_position_o (new_position_o),
    .new_velocity_o (new_velocity_o)
  );

endmodule

// ----- src/rk4smd_checker.sv -----
// port-level checks of the rk4 spring-mass-damper step block, bound to its top
// depends on assert_macros.svh
`include "assert_macros.svh"

module rk4smd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] new_position_o,
  input logic [31:0] new_velocity_o
);

  // a stalled result beat holds
  `RK4_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(new_position_o) && $stable(new_velocity_o), "result beat changed while stalled")

  // one step at a time: busy right after a force beat is taken
  `RK4_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while a step is running")

  // a new result appears only at the end of a busy step
  `RK4_ASSERT(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o), "result raised without a running step")

  // the block is ready for the next force as soon as a result shows
  `RK4_ASSERT(a_ready_with_result, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o, "not ready when result raised")

endmodule

bind rk4_spring_mass_damper_step rk4smd_checker u_checker (.*);
